// ===== hdl/cfs_pkg.sv =====
// Shared types, codes and helpers for the command frame sanitizer.
package cfs_pkg;

  localparam int MaxFrameDef = 128;

  // Parse phases
  localparam logic [2:0] PhStart       = 3'd0;
  localparam logic [2:0] PhAddrFirst   = 3'd1;
  localparam logic [2:0] PhAddr        = 3'd2;
  localparam logic [2:0] PhPass        = 3'd3;
  localparam logic [2:0] PhFixed       = 3'd4;
  localparam logic [2:0] PhPlusOpen    = 3'd5;
  localparam logic [2:0] PhPlusClosed  = 3'd6;

  localparam logic [8:0] AddrBcast = 9'h1FF;
  localparam logic [12:0] AddrMax  = 13'd254;

  localparam logic [7:0] ChM     = 8'h6D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChH     = 8'h68;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] StatusForwarded = 2'd0;
  localparam logic [1:0] StatusQuiet     = 2'd1;
  localparam logic [1:0] StatusEmpty     = 2'd2;
  localparam logic [1:0] StatusTooLong   = 2'd3;

  localparam logic [1:0] KindNone      = 2'd0;
  localparam logic [1:0] KindShowChar  = 2'd1;
  localparam logic [1:0] KindShowIndex = 2'd2;
  localparam logic [1:0] KindHome      = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       raw_mode;
    logic       last_byte;
  } cfs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  forward_length;
    logic [1:0]  motion_kind;
    logic [7:0]  module_address;
    logic        broadcast;
    logic [31:0] frames_sent;
  } cfs_out_t;

  // Fixed-width part of the per-frame parse state
  typedef struct packed {
    logic       raw;
    logic [2:0] phase;
    logic [8:0] addr;
    logic [7:0] cmd;
    logic       home_ok;
  } cfs_parse_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return (b == ChLf) || (b == ChCr);
  endfunction

endpackage

// ===== hdl/command_frame_sanitizer_core.sv =====
// Top level of the command frame sanitizer: input register, parse, result register.
// Accepts one frame byte per cycle with no bubbles while in_stall_o is low. The byte sits in
// an input register; the parse registers update from it, the verdict logic is combinational
// from it, and on a last byte the verdict lands in a result register. in_stall_o rises only
// when the byte in the input register is a last byte and the result register still holds a
// verdict that the consumer is stalling; non-final bytes keep flowing. quiet_time_enable is
// written through cfg_we_i/cfg_data_i; the user must do so only while no frame is in flight,
// which the block does not enforce. MAX_FRAME sets the longest frame that is forwarded.
module command_frame_sanitizer_core #(
  parameter int MAX_FRAME = cfs_pkg::MaxFrameDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cfs_pkg::cfs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cfs_pkg::cfs_out_t out_data_o
);
  import cfs_pkg::*;

  localparam int CntW = $clog2(MAX_FRAME + 2);

  logic       quiet_q;
  logic       s1_valid_q, s1_valid_d;
  cfs_in_t    s1_q;
  logic       adv, commit, in_accept;
  logic       out_valid_q, out_valid_d;
  cfs_out_t   out_q, res;
  cfs_parse_t upd;
  logic [CntW-1:0] upd_count, upd_known, upd_term;

  assign adv        = s1_valid_q && (!s1_q.last_byte || !out_valid_q || !out_stall_i);
  assign commit     = adv && s1_q.last_byte;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = commit ? 1'b1 : (out_valid_q && out_stall_i);

  cfs_frame #(.MAX_FRAME(MAX_FRAME), .CNT_W(CntW)) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_i        (s1_q),
    .upd_o       (upd),
    .upd_count_o (upd_count),
    .upd_known_o (upd_known),
    .upd_term_o  (upd_term)
  );

  cfs_verdict #(.MAX_FRAME(MAX_FRAME), .CNT_W(CntW)) u_verdict (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .quiet_i  (quiet_q),
    .parse_i  (upd),
    .count_i  (upd_count),
    .known_i  (upd_known),
    .term_i   (upd_term),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) quiet_q <= cfg_data_i;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) s1_q <= in_data_i;
    if (commit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/cfs_frame.sv =====
// Per-frame parse registers and their byte-by-byte update.
module cfs_frame #(
  parameter int MAX_FRAME = cfs_pkg::MaxFrameDef,
  parameter int CNT_W     = $clog2(MAX_FRAME + 2)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  cfs_pkg::cfs_in_t     in_i,
  output cfs_pkg::cfs_parse_t  upd_o,
  output logic [CNT_W-1:0]     upd_count_o,
  output logic [CNT_W-1:0]     upd_known_o,
  output logic [CNT_W-1:0]     upd_term_o
);
  import cfs_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRAME);

  cfs_parse_t       st_q, st_d, upd;
  logic [CNT_W-1:0] count_q, count_d, known_q, known_d, term_q, term_d;
  logic [CNT_W-1:0] count_u, known_u, term_u;
  logic [12:0]      acc_next;
  logic [7:0]       b;

  assign b        = in_i.data_byte;
  assign acc_next = ({4'd0, st_q.addr} << 3) + ({4'd0, st_q.addr} << 1) + {9'd0, b[3:0]};

  always_comb begin
    upd     = st_q;
    count_u = count_q;
    known_u = known_q;
    term_u  = term_q;
    if (count_q == '0) begin
      upd.raw = in_i.raw_mode;
    end
    if (count_q < MaxCnt) begin
      unique case (st_q.phase)
        PhStart: begin
          upd.phase = (b == ChM) ? PhAddrFirst : PhPass;
        end
        PhAddrFirst: begin
          if (b == ChStar) begin
            upd.addr  = AddrBcast;
            upd.phase = PhAddr;
          end else if (is_digit(b)) begin
            upd.addr  = {5'd0, b[3:0]};
            upd.phase = PhAddr;
          end else begin
            upd.phase = PhPass;
          end
        end
        PhAddr: begin
          if (st_q.addr != AddrBcast && is_digit(b)) begin
            if (acc_next > AddrMax) upd.phase = PhPass;
            else upd.addr = acc_next[8:0];
          end else begin
            // command byte
            upd.cmd = b;
            if (b == ChH) begin
              known_u     = count_q + CNT_W'(1);
              upd.home_ok = 1'b1;
              upd.phase   = PhFixed;
            end else if (b == ChMinus) begin
              known_u   = count_q + CNT_W'(2);
              upd.phase = PhFixed;
            end else if (b == ChPlus) begin
              known_u   = '0;
              upd.phase = PhPlusOpen;
            end else begin
              upd.phase = PhPass;
            end
          end
        end
        PhFixed: begin
          if (st_q.cmd == ChH && count_q == known_q) upd.home_ok = is_term(b);
        end
        PhPlusOpen: begin
          if (is_digit(b)) known_u = count_q + CNT_W'(1);
          else upd.phase = PhPlusClosed;
        end
        default: begin
        end
      endcase
      term_u = is_term(b) ? term_q + CNT_W'(1) : '0;
    end
    if (count_q <= MaxCnt) begin
      count_u = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    known_d = known_q;
    term_d  = term_q;
    if (adv_i) begin
      if (in_i.last_byte) begin
        st_d    = '{raw: 1'b0, phase: PhStart, addr: '0, cmd: '0, home_ok: 1'b0};
        count_d = '0;
        known_d = '0;
        term_d  = '0;
      end else begin
        st_d    = upd;
        count_d = count_u;
        known_d = known_u;
        term_d  = term_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '{raw: 1'b0, phase: PhStart, addr: '0, cmd: '0, home_ok: 1'b0};
      count_q <= '0;
      known_q <= '0;
      term_q  <= '0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      known_q <= known_d;
      term_q  <= term_d;
    end
  end

  assign upd_o       = upd;
  assign upd_count_o = count_u;
  assign upd_known_o = known_u;
  assign upd_term_o  = term_u;

endmodule

// ===== hdl/cfs_verdict.sv =====
// End-of-frame verdict logic and the forwarded-frame counter.
module cfs_verdict #(
  parameter int MAX_FRAME = cfs_pkg::MaxFrameDef,
  parameter int CNT_W     = $clog2(MAX_FRAME + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,
  input  logic                quiet_i,
  input  cfs_pkg::cfs_parse_t parse_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [CNT_W-1:0]    known_i,
  input  logic [CNT_W-1:0]    term_i,
  output cfs_pkg::cfs_out_t   res_o
);
  import cfs_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRAME);

  logic [31:0]      sent_q;
  logic [CNT_W-1:0] len, bare;
  logic             is_plus;
  cfs_out_t         res;

  assign is_plus = (parse_i.phase == PhPlusOpen) || (parse_i.phase == PhPlusClosed);
  assign len     = parse_i.raw ? count_i : count_i - term_i;

  always_comb begin
    res  = '0;
    bare = len;
    res.frames_sent = sent_q;
    priority if (count_i > MaxCnt) begin
      res.status = StatusTooLong;
    end else if (len == '0) begin
      res.status = StatusEmpty;
    end else begin
      if (!parse_i.raw) begin
        if (parse_i.phase == PhFixed) bare = (known_i < len) ? known_i : len;
        else if (is_plus && known_i != '0) bare = known_i;
      end
      if (parse_i.phase == PhFixed) begin
        if (parse_i.cmd == ChMinus) res.motion_kind = KindShowChar;
        else if (!parse_i.raw || parse_i.home_ok) res.motion_kind = KindHome;
      end else if (is_plus) begin
        res.motion_kind = KindShowIndex;
      end
      if (res.motion_kind != KindNone) begin
        if (parse_i.addr == AddrBcast) res.broadcast = 1'b1;
        else res.module_address = parse_i.addr[7:0];
      end
      if (quiet_i && res.motion_kind != KindNone) begin
        res.status = StatusQuiet;
      end else begin
        res.status         = StatusForwarded;
        res.forward_length = 8'(bare);
        res.frames_sent    = sent_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q <= '0;
    end else if (commit_i) begin
      sent_q <= res.frames_sent;
    end
  end

  assign res_o = res;

endmodule

// ===== hdl/cfs_checker.sv =====
// Port-level assertions for the command frame sanitizer and their bind.
module cfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input cfs_pkg::cfs_out_t out_data_o
);
  import cfs_pkg::*;

  // A stalled verdict stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Input only backs up behind a stalled output
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StatusForwarded |-> out_data_o.forward_length == 8'd0)
    else $error("nonzero length on a frame not forwarded");

  a_no_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motion_kind == KindNone
      |-> !out_data_o.broadcast && out_data_o.module_address == 8'd0)
    else $error("address reported without motion");

  a_bcast_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.broadcast |-> out_data_o.module_address == 8'd0)
    else $error("broadcast with nonzero address");

endmodule

bind command_frame_sanitizer_core cfs_checker u_cfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
